@@ sv/swmp_pkg.sv @@
// Shared types, constants and helpers of the sliding window match peak detector.
package swmp_pkg;

  localparam int QUERY_MAX     = 16;
  localparam int POSITION_BITS = 32;
  localparam int BYTE_W        = 8;
  localparam int LEN_W         = 5;
  localparam int IDX_W         = (QUERY_MAX > 1) ? $clog2(QUERY_MAX) : 1;
  localparam int FILL_W        = $clog2(QUERY_MAX + 1);
  localparam int END_POS_W     = 32;
  localparam int QWORD_W       = 64;
  localparam int SCORE_W       = 6;
  localparam int CFG_IDX_W     = 2;

  localparam logic [QWORD_W-1:0] QUERY_LOW_RST  = 64'h0000_0041_4343_4143;
  localparam logic [QWORD_W-1:0] QUERY_HIGH_RST = 64'h0;
  localparam logic [LEN_W-1:0]   QUERY_LEN_RST  = 5'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUERY_LOW  = 2'd0,
    CFG_QUERY_HIGH = 2'd1,
    CFG_QUERY_LEN  = 2'd2,
    CFG_EXACT_ONLY = 2'd3
  } cfg_reg_t;

  typedef logic [QUERY_MAX-1:0][BYTE_W-1:0] byte_vec_t;

  typedef struct packed {
    logic [FILL_W-1:0]        fill;
    logic [POSITION_BITS-1:0] pos;
  } win_status_t;

  // Query bytes 0..15 split over the two 64-bit registers.
  function automatic byte_vec_t query_bytes(input logic [QWORD_W-1:0] lo,
                                            input logic [QWORD_W-1:0] hi);
    byte_vec_t q;
    for (int i = 0; i < QUERY_MAX; i++) begin
      if (i < 8) q[i] = lo[8*i +: 8];
      else       q[i] = hi[8*(i-8) +: 8];
    end
    return q;
  endfunction

  // Length 0 acts as 1, anything above QUERY_MAX acts as QUERY_MAX.
  function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] n;
    n = len;
    if (n == '0) n = LEN_W'(1);
    if (int'(n) > QUERY_MAX) n = LEN_W'(QUERY_MAX);
    return n;
  endfunction

endpackage

@@ sv/swmp_window.sv @@
// Byte history shift line with fill count and stream position counter.
module swmp_window
  import swmp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              shift_en,
  input  logic [BYTE_W-1:0] shift_byte,
  output byte_vec_t         window_o,
  output win_status_t       status_o
);

  byte_vec_t                store_r, store_nxt;
  logic [FILL_W-1:0]        fill_r, fill_nxt;
  logic [POSITION_BITS-1:0] count_r, count_nxt;

  always_comb begin
    store_nxt = store_r;
    fill_nxt  = fill_r;
    count_nxt = count_r;
    if (shift_en) begin
      for (int i = QUERY_MAX - 1; i > 0; i--) begin
        store_nxt[i] = store_r[i-1];
      end
      store_nxt[0] = shift_byte;
      if (int'(fill_r) < QUERY_MAX) fill_nxt = fill_r + FILL_W'(1);
      count_nxt = count_r + POSITION_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r <= '0;
      fill_r  <= '0;
      count_r <= '0;
    end else begin
      store_r <= store_nxt;
      fill_r  <= fill_nxt;
      count_r <= count_nxt;
    end
  end

  assign window_o        = store_r;
  assign status_o.fill   = fill_r;
  assign status_o.pos    = count_r;

  // The fill count never passes the history depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(fill_r) <= QUERY_MAX)
    else $error("fill count beyond history depth");

  // Each shift advances the position by one.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    shift_en |=> count_r == $past(count_r) + POSITION_BITS'(1))
    else $error("position counter did not advance");

  // Without a shift the history holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !shift_en |=> $stable(store_r) && $stable(fill_r))
    else $error("history changed without a shift");

endmodule

@@ sv/swmp_score.sv @@
// Window alignment and match counting against the query for one window.
module swmp_score
  import swmp_pkg::*;
(
  input  byte_vec_t        hist_i,    // entry 0 newest
  input  byte_vec_t        query_i,
  input  logic [LEN_W-1:0] len_i,     // effective length, 1..QUERY_MAX
  output byte_vec_t        win_o,     // oldest first, unused bytes zero
  output logic [LEN_W-1:0] matches_o
);

  logic [QUERY_MAX-1:0] hit;

  always_comb begin
    logic [LEN_W-1:0] sel;
    win_o = '0;
    hit   = '0;
    for (int i = 0; i < QUERY_MAX; i++) begin
      sel = len_i - LEN_W'(1) - LEN_W'(i);
      if (i < int'(len_i)) begin
        win_o[i] = hist_i[sel[IDX_W-1:0]];
        hit[i]   = (hist_i[sel[IDX_W-1:0]] == query_i[i]);
      end
    end
  end

  assign matches_o = LEN_W'($countones(hit));

endmodule

@@ sv/sliding_window_match_peak.sv @@
// Top level of the sliding window match peak detector.
//
// The block reads a text stream one byte per request on the in_ channel
// and reports peaks of the match score on the out_ channel. A peak is a
// window of the configured query length whose score is positive while the
// window one byte later scores negative. Each match of a window byte with
// its query byte counts +3 and each mismatch -3. In exact mode only
// perfect windows are reported. A result carries the stream position of
// the window's last byte, the window bytes and the score.
// An accepted byte lands in the input register; once the output register
// is free it is scored and its result, if any, is written to the output
// register, from which the receiver takes it. One byte per cycle is
// sustained while in_stall is low: the output register parts the two
// channels, and in_stall rises only while both the input and output
// registers are full and the receiver stalls. Bytes that cause no result
// still advance.
// The cfg_ channel is always ready and must only be used while the block
// is idle. Reset clears history, fill count and position and loads the
// default query "CACCA" of length five with exact mode off.
module sliding_window_match_peak
  import swmp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [END_POS_W-1:0] out_end_position,
  output logic [QWORD_W-1:0]   out_window_low,
  output logic [QWORD_W-1:0]   out_window_high,
  output logic [SCORE_W-1:0]   out_match_score,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [QWORD_W-1:0]   cfg_data
);

  // Configuration registers.
  logic [QWORD_W-1:0] query_low_r, query_high_r;
  logic [LEN_W-1:0]   query_len_r;
  logic               exact_only_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_low_r  <= QUERY_LOW_RST;
      query_high_r <= QUERY_HIGH_RST;
      query_len_r  <= QUERY_LEN_RST;
      exact_only_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_QUERY_LOW:  query_low_r  <= cfg_data;
        CFG_QUERY_HIGH: query_high_r <= cfg_data;
        CFG_QUERY_LEN:  query_len_r  <= cfg_data[LEN_W-1:0];
        CFG_EXACT_ONLY: exact_only_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register and handshake.
  logic              s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free, s1_adv, in_acc;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc)      s1_valid_nxt = 1'b1;
    else if (s1_adv) s1_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else        s1_valid_r <= s1_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_acc) s1_byte_r <= in_byte;
  end

  // History and scoring of the window before and after the shift.
  byte_vec_t        hist, hist_shifted, query, old_win;
  win_status_t      status;
  logic [LEN_W-1:0] n_eff, m_old, m_new;

  swmp_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .shift_en  (s1_adv),
    .shift_byte(s1_byte_r),
    .window_o  (hist),
    .status_o  (status)
  );

  assign query = query_bytes(query_low_r, query_high_r);
  assign n_eff = eff_length(query_len_r);

  always_comb begin
    hist_shifted[0] = s1_byte_r;
    for (int i = 1; i < QUERY_MAX; i++) begin
      hist_shifted[i] = hist[i-1];
    end
  end

  swmp_score u_score_old (
    .hist_i   (hist),
    .query_i  (query),
    .len_i    (n_eff),
    .win_o    (old_win),
    .matches_o(m_old)
  );

  swmp_score u_score_new (
    .hist_i   (hist_shifted),
    .query_i  (query),
    .len_i    (n_eff),
    .win_o    (),
    .matches_o(m_new)
  );

  // A score is 3 * (2 * matches - length); its sign follows the bracket.
  logic signed [7:0] d_old, d_new, score_old;
  logic              filled, peak;

  assign d_old     = $signed({2'b00, m_old, 1'b0}) - $signed({3'b000, n_eff});
  assign d_new     = $signed({2'b00, m_new, 1'b0}) - $signed({3'b000, n_eff});
  assign score_old = (d_old <<< 1) + d_old;
  assign filled    = (FILL_W'(n_eff) <= status.fill);
  assign peak      = filled && (d_old > 0) && (d_new < 0) &&
                     (!exact_only_r || (m_old == n_eff));

  // Result register.
  logic [END_POS_W-1:0] out_pos_r;
  logic [QWORD_W-1:0]   out_lo_r, out_hi_r;
  logic [SCORE_W-1:0]   out_score_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) out_valid_nxt = s1_adv && peak;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (s1_adv && peak) begin
      out_pos_r   <= END_POS_W'(status.pos);
      out_lo_r    <= old_win[7:0];
      out_hi_r    <= old_win[15:8];
      out_score_r <= score_old[SCORE_W-1:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_end_position = out_pos_r;
  assign out_window_low   = out_lo_r;
  assign out_window_high  = out_hi_r;
  assign out_match_score  = out_score_r;

  // A byte waiting behind a stalled result is not lost.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && out_stall |=> s1_valid_r)
    else $error("queued byte dropped while result stalled");

  // A new result is only loaded from a scored byte.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_adv))
    else $error("result appeared without a scored byte");

  // In exact mode a reported score is perfect.
  a_exact: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && exact_only_r |->
      out_score_r == SCORE_W'(3 * int'(n_eff)))
    else $error("non perfect score reported in exact mode");

endmodule

@@ dv/sliding_window_match_peak_checker.sv @@
// Checker for the sliding window match peak detector: predicts peak reports and compares them.
module sliding_window_match_peak_checker
  import swmp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_byte,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [END_POS_W-1:0] out_end_position,
  input  logic [QWORD_W-1:0]   out_window_low,
  input  logic [QWORD_W-1:0]   out_window_high,
  input  logic [SCORE_W-1:0]   out_match_score,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [QWORD_W-1:0]   cfg_data,
  output int                   fail_count,
  output int                   pending_count,
  output int                   peaks_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [END_POS_W-1:0] end_pos;
    logic [QWORD_W-1:0]   win_lo;
    logic [QWORD_W-1:0]   win_hi;
    logic [SCORE_W-1:0]   score;
  } peak_t;

  // Shadow copy of the block's registers and history.
  logic [QWORD_W-1:0]   q_lo;
  logic [QWORD_W-1:0]   q_hi;
  logic [LEN_W-1:0]     q_len;
  logic                 exact_mode;
  logic [BYTE_W-1:0]    history [QUERY_MAX];
  int                   fill_cnt;
  logic [END_POS_W-1:0] byte_cnt;
  peak_t                peak_q [$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
    peaks_checked = 0;
  end

  function automatic int window_score(input byte_vec_t w, input int n);
    int s;
    logic [BYTE_W-1:0] q;
    s = 0;
    for (int i = 0; i < n; i++) begin
      if (i < 8) q = q_lo[8*i +: 8];
      else       q = q_hi[8*(i-8) +: 8];
      s += (w[i] == q) ? 3 : -3;
    end
    return s;
  endfunction

  always @(posedge clk) begin : monitor
    int        n;
    int        s_old;
    int        s_new;
    byte_vec_t old_w;
    byte_vec_t new_w;
    peak_t     got;
    peak_t     want;
    if (!rst_n) begin
      q_lo       = QUERY_LOW_RST;
      q_hi       = QUERY_HIGH_RST;
      q_len      = QUERY_LEN_RST;
      exact_mode = 1'b0;
      for (int i = 0; i < QUERY_MAX; i++) history[i] = '0;
      fill_cnt = 0;
      byte_cnt = '0;
      peak_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_QUERY_LOW:  q_lo = cfg_data;
          CFG_QUERY_HIGH: q_hi = cfg_data;
          CFG_QUERY_LEN:  q_len = cfg_data[LEN_W-1:0];
          CFG_EXACT_ONLY: exact_mode = cfg_data[0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        got = '{out_end_position, out_window_low, out_window_high, out_match_score};
        if (peak_q.size() == 0) begin
          $error("unexpected peak report: end_position %0d score %0d",
                 out_end_position, out_match_score);
          fail_count++;
        end else begin
          want = peak_q.pop_front();
          peaks_checked++;
          if (got.end_pos !== want.end_pos) begin
            $error("end_position: expected %0d, got %0d", want.end_pos, got.end_pos);
            fail_count++;
          end
          if (got.win_lo !== want.win_lo) begin
            $error("window_low: expected %h, got %h", want.win_lo, got.win_lo);
            fail_count++;
          end
          if (got.win_hi !== want.win_hi) begin
            $error("window_high: expected %h, got %h", want.win_hi, got.win_hi);
            fail_count++;
          end
          if (got.score !== want.score) begin
            $error("match_score: expected %0d, got %0d", want.score, got.score);
            fail_count++;
          end
        end
      end

      if (in_valid && !in_stall) begin
        // Length zero acts as one, anything above the maximum as the maximum.
        if (q_len == '0)                n = 1;
        else if (int'(q_len) > QUERY_MAX) n = QUERY_MAX;
        else                              n = int'(q_len);
        if (fill_cnt >= n) begin
          old_w = '0;
          new_w = '0;
          for (int i = 0; i < n; i++) old_w[i] = history[n-1-i];
          for (int i = 0; i < n - 1; i++) new_w[i] = history[n-2-i];
          new_w[n-1] = in_byte;
          s_old = window_score(old_w, n);
          s_new = window_score(new_w, n);
          if (s_old > 0 && s_new < 0 && (!exact_mode || s_old == 3 * n)) begin
            want.end_pos = byte_cnt;
            want.win_lo  = old_w[7:0];
            want.win_hi  = old_w[15:8];
            want.score   = s_old[SCORE_W-1:0];
            peak_q.push_back(want);
          end
        end
        byte_cnt = byte_cnt + 1'b1;
        for (int i = QUERY_MAX - 1; i > 0; i--) history[i] = history[i-1];
        history[0] = in_byte;
        if (fill_cnt < QUERY_MAX) fill_cnt++;
      end
      pending_count = peak_q.size();
    end
  end

endmodule

@@ dv/sliding_window_match_peak_tb.sv @@
// Top of the sliding window match peak testbench: clock, reset, stimulus and verdict.
module sliding_window_match_peak_tb;
  import swmp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Watchdog limit on the cycle count of the run.
  localparam int CYCLE_LIMIT = 300000;
  // Settle time after the last expected result, covering a byte still being scored.
  localparam int SETTLE_CYCLES = 4;
  localparam int SEGMENT_ITEMS = 35;
  localparam int LONG_HOLD     = 300;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [BYTE_W-1:0]    in_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic [END_POS_W-1:0] out_end_position;
  logic [QWORD_W-1:0]   out_window_low;
  logic [QWORD_W-1:0]   out_window_high;
  logic [SCORE_W-1:0]   out_match_score;
  logic                 cfg_valid;
  logic                 cfg_ready;
  cfg_reg_t             cfg_index;
  logic [QWORD_W-1:0]   cfg_data;

  int fail_count;
  int pending_count;
  int peaks_checked;

  // Idle rates in percent for the two sides, and a ticket that asks the
  // receiver process for one long hold-off.
  int sender_idle_pct;
  int receiver_idle_pct;
  int hold_ticket;

  int items_sent;
  int settings_done;
  int cycle_count;

  // Stimulus-side copy of the current query, used to build matching runs.
  logic [QWORD_W-1:0] cur_lo;
  logic [QWORD_W-1:0] cur_hi;
  logic [LEN_W-1:0]   cur_len;

  sliding_window_match_peak DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_end_position (out_end_position),
    .out_window_low   (out_window_low),
    .out_window_high  (out_window_high),
    .out_match_score  (out_match_score),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  sliding_window_match_peak_checker peak_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_end_position (out_end_position),
    .out_window_low   (out_window_low),
    .out_window_high  (out_window_high),
    .out_match_score  (out_match_score),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .pending_count    (pending_count),
    .peaks_checked    (peaks_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: stalls at the configured rate, and when the ticket moves it
  // holds off for a long stretch so that both pipeline registers fill and
  // the block pushes back on its input.
  initial begin : receiver
    int hold_left;
    int seen_ticket;
    hold_left   = 0;
    seen_ticket = 0;
    out_stall   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_ticket != seen_ticket) begin
        seen_ticket = hold_ticket;
        hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(0, 99) < receiver_idle_pct);
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sliding_window_match_peak_tb: errors");
    $finish;
  end

  function automatic logic [BYTE_W-1:0] pick_base();
    case ($urandom_range(0, 3))
      0:       return "A";
      1:       return "C";
      2:       return "G";
      default: return "T";
    endcase
  endfunction

  // Offers one byte request, with random idle cycles in front of it, and
  // returns at the falling edge after the block has taken it.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte  = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Waits until every predicted peak has been reported and the last byte
  // has left the pipeline; the block is idle afterwards.
  task automatic drain();
    in_valid = 1'b0;
    wait (pending_count == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [QWORD_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Writes all four registers. The length and exact-mode writes carry
  // random upper bits, which the block has to ignore.
  task automatic load_query(input logic [QWORD_W-1:0] lo, input logic [QWORD_W-1:0] hi,
                            input logic [LEN_W-1:0] len, input logic exact);
    logic [QWORD_W-1:0] v;
    drain();
    write_reg(CFG_QUERY_LOW, lo);
    write_reg(CFG_QUERY_HIGH, hi);
    v = {$urandom(), $urandom()};
    v[LEN_W-1:0] = len;
    write_reg(CFG_QUERY_LEN, v);
    v = {$urandom(), $urandom()};
    v[0] = exact;
    write_reg(CFG_EXACT_ONLY, v);
    cur_lo  = lo;
    cur_hi  = hi;
    cur_len = len;
    settings_done++;
  endtask

  task automatic load_random_query();
    logic [QWORD_W-1:0] lo;
    logic [QWORD_W-1:0] hi;
    logic [LEN_W-1:0]   len;
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : pick_base();
      hi[8*i +: 8] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : pick_base();
    end
    // Now and then an all-ones or all-zero query word.
    case ($urandom_range(0, 9))
      0: lo = '1;
      1: hi = '1;
      2: lo = '0;
      default: ;
    endcase
    // Bias the length toward its extremes, including the out-of-range codes.
    case ($urandom_range(0, 7))
      0:       len = 5'd0;
      1:       len = 5'd1;
      2:       len = 5'd16;
      3:       len = 5'd31;
      4:       len = 5'($urandom_range(17, 30));
      default: len = 5'($urandom_range(1, 16));
    endcase
    load_query(lo, hi, len, $urandom_range(0, 99) < 30);
  endtask

  // A run of query bytes, each spoiled now and then, closed by a random
  // byte that usually breaks the match and so creates a peak.
  task automatic send_match_run();
    int                n;
    logic [BYTE_W-1:0] b;
    if (cur_len == '0)           n = 1;
    else if (int'(cur_len) > QUERY_MAX) n = QUERY_MAX;
    else                         n = int'(cur_len);
    for (int i = 0; i < n; i++) begin
      b = (i < 8) ? cur_lo[8*i +: 8] : cur_hi[8*(i-8) +: 8];
      if ($urandom_range(0, 99) < 15) b = pick_base();
      send_byte(b);
    end
    send_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : pick_base());
  endtask

  initial begin : stimulus
    int seg_start;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_byte           = '0;
    cfg_valid         = 1'b0;
    cfg_index         = CFG_QUERY_LOW;
    cfg_data          = '0;
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    hold_ticket       = 0;
    items_sent        = 0;
    settings_done     = 0;
    cur_lo            = QUERY_LOW_RST;
    cur_hi            = QUERY_HIGH_RST;
    cur_len           = QUERY_LEN_RST;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. With the reset query the first five bytes only fill
    // the history; the sixth breaks a perfect window and reports it.
    send_byte("C");
    send_byte("A");
    send_byte("C");
    send_byte("C");
    send_byte("A");
    send_byte("Z");

    // A zero length acts as one. The query byte is all ones and exact mode
    // is on, so every all-ones byte followed by another value is a peak.
    load_query('1, '0, 5'd0, 1'b1);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h00);

    // An oversized length acts as the maximum. The history is not yet full
    // when the length grows, so scoring starts only once it holds enough
    // bytes; then the full-length window scores the top value.
    load_query(64'h4847_4645_4443_4241, 64'h504F_4E4D_4C4B_4A49, 5'd31, 1'b0);
    for (int i = 0; i < QUERY_MAX; i++) send_byte(8'h41 + 8'(i));
    send_byte(8'h00);

    // Zero score: the window one byte later scores zero and must not
    // count as negative, nor may a zero-score window count as positive.
    load_query(64'h4241, '0, 5'd2, 1'b0);
    send_byte("A");
    send_byte("B");
    send_byte("B");
    send_byte("A");

    // Random part in three idle regimes: sender idles less than the
    // receiver, then the other way round, then neither idles.
    for (int regime = 0; regime < 3; regime++) begin
      case (regime)
        0: begin
          sender_idle_pct   = 19;
          receiver_idle_pct = 49;
        end
        1: begin
          sender_idle_pct   = 49;
          receiver_idle_pct = 19;
        end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        load_random_query();
        seg_start = items_sent;
        while (items_sent - seg_start < SEGMENT_ITEMS) begin
          if ($urandom_range(0, 99) < 65)
            send_match_run();
          else
            send_byte(($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255)) : pick_base());
        end
      end

      if (regime == 0) begin
        // Back-pressure: a one-byte query makes every "A" followed by "B"
        // a peak, the receiver holds off for a long stretch and the sender
        // keeps offering, so the block has to stall its input. Afterwards
        // the sender pauses until every result has come out.
        load_query(64'h41, '0, 5'd1, 1'b0);
        sender_idle_pct = 0;
        @(posedge clk);
        hold_ticket++;
        @(negedge clk);
        for (int i = 0; i < 60; i++) begin
          send_byte("A");
          send_byte("B");
        end
        drain();
      end
    end

    drain();
    repeat (SETTLE_CYCLES * 2) @(posedge clk);

    $display("Run covered %0d bytes over %0d register settings, %0d peak reports checked.",
             items_sent, settings_done, peaks_checked);
    if (fail_count == 0) begin
      $display("sliding_window_match_peak_tb: clean");
    end else begin
      $display("sliding_window_match_peak_tb: errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/swmp_pkg.sv
sv/swmp_window.sv
sv/swmp_score.sv
sv/sliding_window_match_peak.sv
dv/sliding_window_match_peak_checker.sv
dv/sliding_window_match_peak_tb.sv
